FILE: rtl/imm_pkg.sv
// ----------------------------------------------------------------------------
// Integer matrix multiply package
// Shared widths, the item kind codes and the control word that travels
// alongside operands into the multiply-accumulate unit.
// ----------------------------------------------------------------------------
package imm_pkg;

   localparam int IDX_WIDTH  = 3;
   localparam int ADDR_WIDTH = 2 * IDX_WIDTH;
   localparam int ELEM_WIDTH = 16;
   localparam int PROD_WIDTH = 2 * ELEM_WIDTH;
   localparam int ACC_WIDTH  = 35;

   typedef enum logic [1:0] {
      KIND_LOAD_A = 2'd0,
      KIND_LOAD_B = 2'd1,
      KIND_START  = 2'd2,
      KIND_UNUSED = 2'd3
   } imm_kind_type;

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } imm_ctl_type;

endpackage

FILE: rtl/imm_if.sv
// ----------------------------------------------------------------------------
// Integer matrix multiply channel interfaces
// Valid/ready channels for request transactions and result transactions.
// ----------------------------------------------------------------------------
interface imm_req_if
   import imm_pkg::*;
   ();
   logic                         valid;
   logic                         ready;
   logic [1:0]                   kind;
   logic [IDX_WIDTH-1:0]         row;
   logic [IDX_WIDTH-1:0]         col;
   logic signed [ELEM_WIDTH-1:0] element;

   modport source (output valid, output kind, output row, output col, output element,
                   input ready);
   modport sink (input valid, input kind, input row, input col, input element,
                 output ready);
endinterface

interface imm_rsp_if
   import imm_pkg::*;
   ();
   logic                        valid;
   logic                        ready;
   logic [IDX_WIDTH-1:0]        out_row;
   logic [IDX_WIDTH-1:0]        out_col;
   logic signed [ACC_WIDTH-1:0] product_value;
   logic                        last;

   modport source (output valid, output out_row, output out_col, output product_value,
                   output last, input ready);
   modport sink (input valid, input out_row, input out_col, input product_value,
                 input last, output ready);
endinterface

FILE: rtl/imm_store.sv
// ----------------------------------------------------------------------------
// Integer matrix multiply element store
// One 64-entry memory of matrix elements with a write port and a registered
// read port.
// ----------------------------------------------------------------------------
module imm_store
   import imm_pkg::*;
(
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [ADDR_WIDTH-1:0]        wr_addr,
   input  logic signed [ELEM_WIDTH-1:0] wr_data,
   input  logic [ADDR_WIDTH-1:0]        rd_addr,
   output logic signed [ELEM_WIDTH-1:0] rd_data
);

   logic signed [ELEM_WIDTH-1:0] mem [2**ADDR_WIDTH];
   logic signed [ELEM_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/imm_mac.sv
// ----------------------------------------------------------------------------
// Integer matrix multiply accumulate unit
// Shared signed multiplier followed by a full-width accumulator; the product
// and the running sum are each registered.
// ----------------------------------------------------------------------------
module imm_mac
   import imm_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic signed [ELEM_WIDTH-1:0] operand_a,
   input  logic signed [ELEM_WIDTH-1:0] operand_b,
   input  imm_ctl_type                  ctl,
   output logic signed [ACC_WIDTH-1:0]  acc,
   output logic                         done
);

   logic signed [PROD_WIDTH-1:0] product_ff;
   logic signed [PROD_WIDTH-1:0] product_in;
   imm_ctl_type                  ctl_ff;
   logic signed [ACC_WIDTH-1:0]  acc_ff;
   logic signed [ACC_WIDTH-1:0]  acc_in;
   logic                         done_ff;
   logic                         done_in;

   always_comb begin
      product_in = operand_a * operand_b;
      acc_in     = acc_ff;
      if (ctl_ff.valid) begin
         if (ctl_ff.first) begin
            acc_in = ACC_WIDTH'(product_ff);
         end else begin
            acc_in = acc_ff + ACC_WIDTH'(product_ff);
         end
      end
      done_in = ctl_ff.valid & ctl_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         ctl_ff  <= ctl;
         done_ff <= done_in;
      end
      product_ff <= product_in;
      acc_ff     <= acc_in;
   end

   assign acc  = acc_ff;
   assign done = done_ff;

endmodule

FILE: rtl/integer_matrix_multiply_top.sv
// ----------------------------------------------------------------------------
// Integer matrix multiply top level
// Stores the A and B matrices and computes C = A x B with one shared
// multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Usage:
// The request channel carries three kinds of transaction. A load of A or B
// writes one element and gives no result; a load outside the MATRIX_SIZE
// square and the unused kind are dropped. A start computes all
// MATRIX_SIZE*MATRIX_SIZE elements of C and sends them on the result
// channel in row-major order, the final one carrying last.
// Each result element takes one store read per term into the single
// multiply-accumulate unit, then the memory read, multiplier and
// accumulator registers drain before the sum is handed on. A start thus
// occupies the block, including any time the result receiver stalls, until
// the final result has been placed in the output register; the request
// channel is not ready until then.
// A stalled receiver holds the sequencer at the output step, with the
// result register kept intact. Loads are accepted while a result still waits.
// Reset empties the output register and returns the sequencer to idle; the
// matrix stores are not cleared and must be loaded before a start.
// ----------------------------------------------------------------------------
module integer_matrix_multiply_top
   import imm_pkg::*;
#(
   parameter int MATRIX_SIZE = 8
)
(
   input  logic      clock,
   input  logic      reset,
   imm_req_if.sink   req_chan,
   imm_rsp_if.source rsp_chan
);

   localparam logic [IDX_WIDTH-1:0] LAST_IDX = IDX_WIDTH'(MATRIX_SIZE - 1);
   localparam logic [IDX_WIDTH:0]   SIZE_VAL = (IDX_WIDTH + 1)'(MATRIX_SIZE);

   typedef enum logic [1:0] {
      S_IDLE,
      S_ISSUE,
      S_WAIT,
      S_OUTPUT
   } state_type;

   state_type                   state_ff, state_in;
   logic [IDX_WIDTH-1:0]        row_ff, row_in;
   logic [IDX_WIDTH-1:0]        col_ff, col_in;
   logic [IDX_WIDTH-1:0]        k_ff, k_in;
   imm_ctl_type                 issue_ctl_ff, issue_ctl_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [IDX_WIDTH-1:0]        rsp_row_ff, rsp_row_in;
   logic [IDX_WIDTH-1:0]        rsp_col_ff, rsp_col_in;
   logic signed [ACC_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic                         in_range;
   logic                         wr_en_a;
   logic                         wr_en_b;
   logic [ADDR_WIDTH-1:0]        wr_addr;
   logic signed [ELEM_WIDTH-1:0] data_a;
   logic signed [ELEM_WIDTH-1:0] data_b;
   logic signed [ACC_WIDTH-1:0]  mac_acc;
   logic                         mac_done;

   assign in_range = ({1'b0, req_chan.row} < SIZE_VAL) && ({1'b0, req_chan.col} < SIZE_VAL);
   assign wr_addr  = {req_chan.row, req_chan.col};

   imm_store u_store_a (
      .clock   (clock),
      .wr_en   (wr_en_a),
      .wr_addr (wr_addr),
      .wr_data (req_chan.element),
      .rd_addr ({row_ff, k_ff}),
      .rd_data (data_a)
   );

   imm_store u_store_b (
      .clock   (clock),
      .wr_en   (wr_en_b),
      .wr_addr (wr_addr),
      .wr_data (req_chan.element),
      .rd_addr ({k_ff, col_ff}),
      .rd_data (data_b)
   );

   imm_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .operand_a (data_a),
      .operand_b (data_b),
      .ctl       (issue_ctl_ff),
      .acc       (mac_acc),
      .done      (mac_done)
   );

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      k_in         = k_ff;
      issue_ctl_in = '0;
      rsp_valid_in = rsp_valid_ff & ~rsp_chan.ready;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      wr_en_a      = 1'b0;
      wr_en_b      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               case (imm_kind_type'(req_chan.kind))
                  KIND_LOAD_A: begin
                     wr_en_a = in_range;
                  end
                  KIND_LOAD_B: begin
                     wr_en_b = in_range;
                  end
                  KIND_START: begin
                     state_in = S_ISSUE;
                     row_in   = '0;
                     col_in   = '0;
                     k_in     = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_ISSUE: begin
            issue_ctl_in.valid = 1'b1;
            issue_ctl_in.first = (k_ff == '0);
            issue_ctl_in.last  = (k_ff == LAST_IDX);
            if (k_ff == LAST_IDX) begin
               k_in     = '0;
               state_in = S_WAIT;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         S_WAIT: begin
            if (mac_done) begin
               state_in = S_OUTPUT;
            end
         end
         S_OUTPUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = row_ff;
               rsp_col_in   = col_ff;
               rsp_value_in = mac_acc;
               rsp_last_in  = (row_ff == LAST_IDX) && (col_ff == LAST_IDX);
               if (col_ff == LAST_IDX) begin
                  col_in = '0;
                  if (row_ff == LAST_IDX) begin
                     row_in   = '0;
                     state_in = S_IDLE;
                  end else begin
                     row_in   = row_ff + 1'b1;
                     state_in = S_ISSUE;
                  end
               end else begin
                  col_in   = col_ff + 1'b1;
                  state_in = S_ISSUE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         k_ff         <= '0;
         issue_ctl_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         k_ff         <= k_in;
         issue_ctl_ff <= issue_ctl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_chan.ready         = (state_ff == S_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.out_row       = rsp_row_ff;
   assign rsp_chan.out_col       = rsp_col_ff;
   assign rsp_chan.product_value = rsp_value_ff;
   assign rsp_chan.last          = rsp_last_ff;

endmodule

FILE: tb/integer_matrix_multiply_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Integer matrix multiply testbench
// Loads both matrices, then sends extreme-valued rows and columns, unused
// kinds and repeated starts, followed by random runs of loads, most of
// which end in a start. Every accepted load updates a local copy of the
// matrices, and each start queues the full row-major product. Result
// transactions are checked field by field against that queue. Both channels
// idle in random bursts.
// ----------------------------------------------------------------------------
module integer_matrix_multiply_top_tb;
   import imm_pkg::*;

   localparam int MATRIX_SIZE = 8;
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct {
      imm_kind_type                 kind;
      logic [IDX_WIDTH-1:0]         row;
      logic [IDX_WIDTH-1:0]         col;
      logic signed [ELEM_WIDTH-1:0] element;
      bit                           drain;
   } matrix_request_type;

   typedef struct {
      logic [IDX_WIDTH-1:0]        row;
      logic [IDX_WIDTH-1:0]        col;
      logic signed [ACC_WIDTH-1:0] value;
      logic                        last;
   } product_entry_type;

   logic clock;
   logic reset;

   imm_req_if req_if ();
   imm_rsp_if rsp_if ();

   integer_matrix_multiply_top #(
      .MATRIX_SIZE(MATRIX_SIZE)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   logic signed [ELEM_WIDTH-1:0] left_matrix [8][8];
   logic signed [ELEM_WIDTH-1:0] right_matrix [8][8];

   matrix_request_type pending_requests [$];
   product_entry_type  expected_products [$];
   matrix_request_type request_on_wire;

   int  mismatch_count = 0;
   int  cycle_count = 0;
   int  send_gap = 0;
   int  stall_left = 0;
   bit  quiet_tail = 1'b0;

   always #2 clock = ~clock;

   task automatic report_mismatch(input string message);
      $display("%0t: %s", $realtime, message);
      mismatch_count++;
   endtask

   function automatic logic signed [ELEM_WIDTH-1:0] random_element();
      case ($urandom_range(0, 9))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return '1;
         3: return '0;
         default: return ELEM_WIDTH'($urandom);
      endcase
   endfunction

   task automatic push_request(input imm_kind_type kind, input int row, input int col,
                               input logic signed [ELEM_WIDTH-1:0] element, input bit drain);
      matrix_request_type item;
      item.kind    = kind;
      item.row     = IDX_WIDTH'(row);
      item.col     = IDX_WIDTH'(col);
      item.element = element;
      item.drain   = drain;
      pending_requests.push_back(item);
   endtask

   task automatic predict_request(input matrix_request_type item);
      product_entry_type entry;
      longint            sum;
      if (item.kind == KIND_LOAD_A || item.kind == KIND_LOAD_B) begin
         if (item.row < MATRIX_SIZE && item.col < MATRIX_SIZE) begin
            if (item.kind == KIND_LOAD_A) begin
               left_matrix[item.row][item.col] = item.element;
            end else begin
               right_matrix[item.row][item.col] = item.element;
            end
         end
      end else if (item.kind == KIND_START) begin
         for (int r = 0; r < MATRIX_SIZE; r++) begin
            for (int c = 0; c < MATRIX_SIZE; c++) begin
               sum = 0;
               for (int k = 0; k < MATRIX_SIZE; k++) begin
                  sum += longint'(left_matrix[r][k]) * longint'(right_matrix[k][c]);
               end
               entry.row   = IDX_WIDTH'(r);
               entry.col   = IDX_WIDTH'(c);
               entry.value = sum[ACC_WIDTH-1:0];
               entry.last  = (r == MATRIX_SIZE - 1) && (c == MATRIX_SIZE - 1);
               expected_products.push_back(entry);
            end
         end
      end
   endtask

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            predict_request(request_on_wire);
         end
         if (!req_if.valid || req_if.ready) begin
            quiet_tail = pending_requests.size() < 40;
            if (send_gap > 0) begin
               send_gap--;
               req_if.valid <= 1'b0;
            end else if (pending_requests.size() > 0 &&
                         !(pending_requests[0].drain && expected_products.size() > 0)) begin
               request_on_wire = pending_requests.pop_front();
               req_if.valid   <= 1'b1;
               req_if.kind    <= request_on_wire.kind;
               req_if.row     <= request_on_wire.row;
               req_if.col     <= request_on_wire.col;
               req_if.element <= request_on_wire.element;
               if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                  send_gap = $urandom_range(1, 7);
               end
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      product_entry_type entry;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_products.size() == 0) begin
               report_mismatch($sformatf("unexpected result at row %0d col %0d",
                                         rsp_if.out_row, rsp_if.out_col));
            end else begin
               entry = expected_products.pop_front();
               if (rsp_if.out_row !== entry.row) begin
                  report_mismatch($sformatf("out_row %0d, expected %0d",
                                            rsp_if.out_row, entry.row));
               end
               if (rsp_if.out_col !== entry.col) begin
                  report_mismatch($sformatf("out_col %0d, expected %0d",
                                            rsp_if.out_col, entry.col));
               end
               if (rsp_if.product_value !== entry.value) begin
                  report_mismatch($sformatf("product (%0d,%0d) %0d, expected %0d",
                                            entry.row, entry.col,
                                            rsp_if.product_value, entry.value));
               end
               if (rsp_if.last !== entry.last) begin
                  report_mismatch($sformatf("last %b at (%0d,%0d), expected %b",
                                            rsp_if.last, entry.row, entry.col, entry.last));
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(0, 6);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles", cycle_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      int  run_length;
      int  load_count;
      bit  is_left;
      clock          = 1'b0;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.kind    = KIND_LOAD_A;
      req_if.row     = '0;
      req_if.col     = '0;
      req_if.element = '0;
      rsp_if.ready   = 1'b0;

      // Every entry of both matrices is written before the first start.
      for (int r = 0; r < MATRIX_SIZE; r++) begin
         for (int c = 0; c < MATRIX_SIZE; c++) begin
            push_request(KIND_LOAD_A, r, c, random_element(), 1'b0);
            push_request(KIND_LOAD_B, r, c, random_element(), 1'b0);
         end
      end

      // Extreme operands give the largest positive and negative dot products.
      for (int k = 0; k < MATRIX_SIZE; k++) begin
         push_request(KIND_LOAD_A, 0, k, 16'sh8000, 1'b0);
         push_request(KIND_LOAD_B, k, 0, 16'sh8000, 1'b0);
         push_request(KIND_LOAD_B, k, MATRIX_SIZE - 1, 16'sh7fff, 1'b0);
      end
      push_request(KIND_UNUSED, 7, 7, '1, 1'b0);
      push_request(KIND_START, $urandom_range(0, 7), $urandom_range(0, 7),
                   random_element(), 1'b0);
      push_request(KIND_START, 7, 7, 16'sh7fff, 1'b1);

      load_count = 0;
      while (load_count < 205) begin
         run_length = $urandom_range(0, 40);
         for (int i = 0; i < run_length; i++) begin
            if ($urandom_range(0, 19) == 0) begin
               push_request(KIND_UNUSED, $urandom_range(0, 7), $urandom_range(0, 7),
                            random_element(), 1'b0);
            end else begin
               is_left = 1'($urandom_range(0, 1));
               push_request(is_left ? KIND_LOAD_A : KIND_LOAD_B, $urandom_range(0, 7),
                            $urandom_range(0, 7), random_element(), 1'b0);
               load_count++;
            end
         end
         if ($urandom_range(0, 7) != 0) begin
            push_request(KIND_START, $urandom_range(0, 7), $urandom_range(0, 7),
                         random_element(), $urandom_range(0, 3) == 0);
            load_count++;
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      @(posedge clock);
      while (pending_requests.size() != 0 || req_if.valid || expected_products.size() != 0) begin
         @(posedge clock);
      end
      repeat (2 * (MATRIX_SIZE + 4)) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
